// File: rtl/waveform_peak_binner_assert.svh
// assertion macros for the waveform peak binner checker
// expects clk and rst_n in the scope where a macro is used
`ifndef WAVEFORM_PEAK_BINNER_ASSERT_SVH
`define WAVEFORM_PEAK_BINNER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define WPB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define WPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/wpb_pkg.sv
// shared constants, register codes and control structs of the peak binner
// no dependencies
package wpb_pkg;

  localparam int TOTAL_W         = 32;
  localparam int BINCNT_W        = 13;
  localparam int BIN_W           = 12;
  localparam int CFG_W           = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int MAX_BINS_DEF    = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam logic [BINCNT_W-1:0]  BINCNT_RESET = 13'd256;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BINS  = 2'd1;

  // controller to datapath
  typedef struct packed {
    logic div_start;
    logic load;
    logic run_en;
  } wpb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cfg_hit;
    logic div_done;
  } wpb_sts_t;

endpackage

// File: rtl/wpb_ifs.sv
// valid/ready stream interfaces for samples in and peaks out
// depends on wpb_pkg
interface wpb_in_if #(
  parameter int SAMPLE_BITS = wpb_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wpb_out_if #(
  parameter int SAMPLE_BITS = wpb_pkg::SAMPLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [SAMPLE_BITS-2:0]       peak;
  logic [wpb_pkg::BIN_W-1:0]    bin_index;
  logic                         last_bin;

  modport source (output valid, output peak, output bin_index, output last_bin, input ready);
  modport sink   (input valid, input peak, input bin_index, input last_bin, output ready);
endinterface

// File: rtl/wpb_div.sv
// restoring divider, one quotient bit per cycle, total by bin count
// depends on wpb_pkg
module wpb_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [wpb_pkg::TOTAL_W-1:0]    dividend,
  input  logic [wpb_pkg::BINCNT_W-1:0]   divisor,
  output logic                           done,
  output logic [wpb_pkg::TOTAL_W-1:0]    quot,
  output logic [wpb_pkg::BINCNT_W-1:0]   rem
);

  localparam int CNT_W = $clog2(wpb_pkg::TOTAL_W);

  logic                          busy_r;
  logic                          done_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [wpb_pkg::TOTAL_W-1:0]   dvd_r;
  logic [wpb_pkg::BINCNT_W-1:0]  rem_r;
  logic [wpb_pkg::BINCNT_W-1:0]  dsr_r;

  logic [wpb_pkg::BINCNT_W:0]    trial;
  logic [wpb_pkg::BINCNT_W:0]    diff;
  logic                          ge;

  always_comb begin
    trial = {rem_r, dvd_r[wpb_pkg::TOTAL_W-1]};
    diff  = trial - {1'b0, dsr_r};
    ge    = (trial >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(wpb_pkg::TOTAL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[wpb_pkg::BINCNT_W-1:0] : trial[wpb_pkg::BINCNT_W-1:0];
      dvd_r <= {dvd_r[wpb_pkg::TOTAL_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule

// File: rtl/wpb_dp.sv
// datapath: config registers, divider, bin boundary tracking, peak and output register
// depends on wpb_pkg and wpb_div
module wpb_dp #(
  parameter int MAX_BINS    = wpb_pkg::MAX_BINS_DEF,
  parameter int SAMPLE_BITS = wpb_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wpb_pkg::wpb_cmd_t               cmd,
  output wpb_pkg::wpb_sts_t               sts,
  input  logic                            cfg_we,
  input  logic [wpb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wpb_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [SAMPLE_BITS-2:0]          out_peak,
  output logic [wpb_pkg::BIN_W-1:0]       out_bin_index,
  output logic                            out_last_bin
);

  localparam int PEAK_W = SAMPLE_BITS - 1;
  localparam int TW     = wpb_pkg::TOTAL_W;
  localparam int CW     = wpb_pkg::BINCNT_W;
  localparam int BW     = wpb_pkg::BIN_W;

  // config registers
  logic [TW-1:0]     total_r;
  logic [CW-1:0]     bincnt_r;
  logic              cfg_hit;

  // effective bin count
  logic [CW-1:0]     bins_sat;
  logic [CW-1:0]     eff;
  logic [CW-1:0]     eff_r;

  // divider results
  logic              div_done;
  logic [TW-1:0]     quot;
  logic [CW-1:0]     rem;

  // binning state
  logic [TW-1:0]     cnt_r,  cnt_nxt;
  logic [BW-1:0]     bin_r,  bin_nxt;
  logic [TW-1:0]     end_r,  end_nxt;
  logic [CW-1:0]     acc_r,  acc_nxt;
  logic [PEAK_W-1:0] peak_r, peak_nxt;

  // output register
  logic              ov_r,   ov_nxt;
  logic [PEAK_W-1:0] opeak_r;
  logic [BW-1:0]     obin_r;
  logic              olast_r;

  logic              fire;
  logic [SAMPLE_BITS-1:0] neg_s;
  logic [PEAK_W-1:0] mag;
  logic [PEAK_W-1:0] peak_new;
  logic [TW:0]       taken;
  logic              hit;
  logic              last;
  logic [CW:0]       acc_sum;
  logic              carry;

  assign cfg_hit = cfg_we && (cfg_index == wpb_pkg::REG_TOTAL || cfg_index == wpb_pkg::REG_BINS);
  assign sts.cfg_hit  = cfg_hit;
  assign sts.div_done = div_done;

  always_comb begin
    if (32'(bincnt_r) > 32'(MAX_BINS)) bins_sat = CW'(MAX_BINS);
    else                               bins_sat = bincnt_r;
    if (TW'(bins_sat) > total_r) eff = total_r[CW-1:0];
    else                         eff = bins_sat;
  end

  wpb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (total_r),
    .divisor  (eff),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      bincnt_r <= wpb_pkg::BINCNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wpb_pkg::REG_TOTAL: total_r  <= cfg_data[TW-1:0];
        wpb_pkg::REG_BINS:  bincnt_r <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // input taken when running and the output slot is free or draining
  assign in_ready = cmd.run_en && (!ov_r || out_ready);
  assign fire     = in_valid && in_ready;

  // saturating magnitude
  always_comb begin
    neg_s = SAMPLE_BITS'(~in_sample) + 1'b1;
    if (!in_sample[SAMPLE_BITS-1]) mag = in_sample[PEAK_W-1:0];
    else if (neg_s[SAMPLE_BITS-1]) mag = '1;
    else                           mag = neg_s[PEAK_W-1:0];
    peak_new = (mag > peak_r) ? mag : peak_r;
  end

  always_comb begin
    taken   = {1'b0, cnt_r} + 1'b1;
    hit     = (taken >= {1'b0, end_r});
    last    = ((CW'(bin_r) + 1'b1) >= eff_r);
    acc_sum = {1'b0, acc_r} + {1'b0, rem};
    carry   = (acc_sum >= {1'b0, eff_r});

    cnt_nxt  = cnt_r;
    bin_nxt  = bin_r;
    end_nxt  = end_r;
    acc_nxt  = acc_r;
    peak_nxt = peak_r;
    ov_nxt   = ov_r && !out_ready;

    if (cfg_hit) begin
      cnt_nxt  = '0;
      bin_nxt  = '0;
      peak_nxt = '0;
    end else if (cmd.load) begin
      end_nxt = quot;
      acc_nxt = rem;
    end else if (fire && eff_r != '0) begin
      cnt_nxt = taken[TW-1:0];
      if (!hit) begin
        peak_nxt = peak_new;
      end else begin
        ov_nxt   = 1'b1;
        peak_nxt = '0;
        if (last) begin
          cnt_nxt = '0;
          bin_nxt = '0;
          end_nxt = quot;
          acc_nxt = rem;
        end else begin
          bin_nxt = bin_r + 1'b1;
          if (bin_r == '1) begin
            // bin number wraps: boundary restarts from the first bin
            end_nxt = quot;
            acc_nxt = rem;
          end else if (carry) begin
            end_nxt = end_r + quot + 1'b1;
            acc_nxt = CW'(acc_sum - {1'b0, eff_r});
          end else begin
            end_nxt = end_r + quot;
            acc_nxt = acc_sum[CW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      bin_r  <= '0;
      peak_r <= '0;
      eff_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      bin_r  <= bin_nxt;
      peak_r <= peak_nxt;
      ov_r   <= ov_nxt;
      if (cmd.div_start) eff_r <= eff;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    end_r <= end_nxt;
    acc_r <= acc_nxt;
    if (fire && hit && eff_r != '0 && !cfg_hit && !cmd.load) begin
      opeak_r <= peak_new;
      obin_r  <= bin_r;
      olast_r <= last;
    end
  end

  assign out_valid     = ov_r;
  assign out_peak      = opeak_r;
  assign out_bin_index = obin_r;
  assign out_last_bin  = olast_r;

endmodule

// File: rtl/wpb_ctrl.sv
// controller: sequences the boundary division after each register write
// depends on wpb_pkg
module wpb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  wpb_pkg::wpb_sts_t  sts,
  output wpb_pkg::wpb_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_START,
    ST_DIV,
    ST_LOAD
  } state_t;

  state_t            state_r, state_nxt;
  wpb_pkg::wpb_cmd_t cmd_r;

  always_comb begin
    state_nxt = state_r;
    if (sts.cfg_hit) begin
      state_nxt = ST_START;
    end else begin
      unique case (state_r)
        ST_RUN:   state_nxt = ST_RUN;
        ST_START: state_nxt = ST_DIV;
        ST_DIV:   if (sts.div_done) state_nxt = ST_LOAD;
        ST_LOAD:  state_nxt = ST_RUN;
        default:  state_nxt = ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RUN;
      cmd_r.div_start <= 1'b0;
      cmd_r.load      <= 1'b0;
      cmd_r.run_en    <= 1'b1;
    end else begin
      state_r         <= state_nxt;
      cmd_r.div_start <= (state_nxt == ST_START);
      cmd_r.load      <= (state_nxt == ST_LOAD);
      cmd_r.run_en    <= (state_nxt == ST_RUN);
    end
  end

  assign cmd = cmd_r;

endmodule

// File: rtl/waveform_peak_binner.sv
// top level of the waveform peak binner: controller plus datapath
// depends on wpb_pkg, wpb_ifs, wpb_ctrl, wpb_dp (and wpb_div below it)
//
// channel   | dir | handshake      | beat payload
// ----------+-----+----------------+----------------------------------
// in_ch     | in  | valid / ready  | sample (signed, SAMPLE_BITS)
// out_ch    | out | valid / ready  | peak, bin_index, last_bin
// cfg_*     | in  | cfg_we only    | cfg_index, cfg_data (32 bits)
//
// one sample beat per cycle while running; a bin closes on the beat that
// takes its final sample, and its peak is valid on out_ch from the next cycle
// each register write rearms the channel and reruns the restoring divider
// (total by bin count, one bit a cycle): in_ch.ready is low until boundaries load
// synchronous active-low reset: total 0, bin count 256, no bins, ready high
// otherwise in_ch.ready drops only while a result beat waits with out_ch.ready low
module waveform_peak_binner #(
  parameter int MAX_BINS    = wpb_pkg::MAX_BINS_DEF,
  parameter int SAMPLE_BITS = wpb_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  wpb_in_if.sink                         in_ch,
  wpb_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [wpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wpb_pkg::CFG_W-1:0]      cfg_data
);

  // command and status between the two halves
  wpb_pkg::wpb_cmd_t cmd;
  wpb_pkg::wpb_sts_t sts;

  // sequencing: run, then divide after a register write, then load boundaries
  wpb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // counters, boundary accumulator, running peak and the output register
  wpb_dp #(
    .MAX_BINS    (MAX_BINS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_sample     (in_ch.sample),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_peak      (out_ch.peak),
    .out_bin_index (out_ch.bin_index),
    .out_last_bin  (out_ch.last_bin)
  );

endmodule

// File: rtl/wpb_checker.sv
// port-level assertions for the waveform peak binner, bound to the top level
// depends on wpb_pkg and waveform_peak_binner_assert.svh
`include "waveform_peak_binner_assert.svh"

module wpb_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [wpb_pkg::BIN_W-1:0]      out_bin_index,
  input logic                           out_last_bin,
  input logic                           cfg_we,
  input logic [wpb_pkg::CFG_IDX_W-1:0]  cfg_index
);

  logic                      out_fire;
  logic                      cfg_hit;
  logic                      stalled;
  logic [wpb_pkg::BIN_W-1:0] bin_inc;

  assign out_fire = out_valid && out_ready;
  assign stalled  = out_valid && !out_ready;
  assign bin_inc  = out_bin_index + 1'b1;
  assign cfg_hit  = cfg_we && (cfg_index == wpb_pkg::REG_TOTAL ||
                               cfg_index == wpb_pkg::REG_BINS);

  `WPB_ASSERT_NEXT(a_out_hold, stalled, out_valid, "result beat dropped while stalled")
  `WPB_ASSERT_NOW(a_stall_blocks_in, stalled, !in_ready, "sample taken while result waits")
  `WPB_ASSERT_NEXT(a_cfg_rearm, cfg_hit, !in_ready, "sample taken before boundaries set")
  `WPB_ASSERT_NOW(a_bin_step, (out_fire && !out_last_bin && !cfg_we) ##1 out_fire, out_bin_index == $past(bin_inc), "bins out of order")

endmodule

bind waveform_peak_binner wpb_checker u_wpb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_bin_index (out_ch.bin_index),
  .out_last_bin  (out_ch.last_bin),
  .cfg_we        (cfg_we),
  .cfg_index     (cfg_index)
);
